// ===== rtl/ptt_pkg.sv =====
package ptt_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_SLOTS_DEF = 16;
  localparam int STEP_MS_DEF   = 10;

  // Fixed field widths
  localparam int DATA_W = 24;
  localparam int SLOT_W = 6;
  localparam int CMD_W  = 2;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REG   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNREG = 2'd2;

  // Reply status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_PERIOD   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // Result kinds
  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              op_tick;
    logic              op_reg;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_idx;
    logic [DATA_W-1:0] reload;
    logic [DATA_W-1:0] count;
    logic [MODE_W-1:0] mode;
  } cell_bus_t;

  // Per-cell status
  typedef struct packed {
    logic              valid;
    logic              expire;
    logic              claim;
    logic [MODE_W-1:0] mode;
  } cell_stat_t;

  // Merged status of the cell row, seen by the controller
  typedef struct packed {
    logic              hit;
    logic              claim;
    logic              srch_end;
    logic [MODE_W-1:0] mode;
  } scan_stat_t;

endpackage

// ===== rtl/ptt_div.sv =====
// Divide by the constant STEP_MS with a reciprocal multiply. The dividend is
// registered, then multiplied by ceil(2^SH / STEP_MS), and the quotient is the
// top DATA_W bits of the product. SH = DATA_W + clog2(STEP_MS) keeps the result
// exact for every DATA_W-bit dividend. run is high for the multiply cycle.
module ptt_div #(
  parameter int STEP_MS = ptt_pkg::STEP_MS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ptt_pkg::DATA_W-1:0] dividend,
  output logic                       run,
  output logic [ptt_pkg::DATA_W-1:0] quotient
);

  localparam int DW = ptt_pkg::DATA_W;
  localparam int MW = DW + 1;
  localparam int SH = DW + $clog2(STEP_MS);
  localparam int PW = SH + DW;
  localparam longint RECIP =
    ((longint'(1) << SH) + longint'(STEP_MS) - longint'(1)) / longint'(STEP_MS);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic [DW-1:0] dvd;
  logic [PW-1:0] prod;

  assign quotient = prod[PW-1:SH];

  // Busy flag: set in the cycle after start, for the multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else begin
      run <= start;
    end
  end

  // Capture the dividend, then multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (run) begin
      prod <= {{(PW-DW){1'b0}}, dvd} * {{(PW-MW){1'b0}}, RECIP_C};
    end
  end

endmodule

// ===== rtl/ptt_cell.sv =====
// One timer slot. A token walks the row; the holder acts on a broadcast
// tick or register and hands the token and search flag to its neighbor.
module ptt_cell #(
  parameter int CELL_ID = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  ptt_pkg::cell_bus_t  bus,
  input  logic                tok_in,
  input  logic                srch_in,
  output logic                tok_out,
  output logic                srch_out,
  output ptt_pkg::cell_stat_t stat
);

  logic                       tok;
  logic                       srch;
  logic                       valid;
  logic [ptt_pkg::DATA_W-1:0] reload;
  logic [ptt_pkg::DATA_W-1:0] count;
  logic [ptt_pkg::MODE_W-1:0] mode;
  logic                       act_tick;
  logic                       expire;
  logic                       claim;
  logic                       clr_hit;

  always_comb begin
    act_tick = bus.op_tick & tok & valid;
    expire   = act_tick & (count <= ptt_pkg::DATA_W'(1));
    claim    = bus.op_reg & tok & srch & ~valid;
    clr_hit  = bus.clr_en & (bus.clr_idx == ptt_pkg::SLOT_W'(CELL_ID));
  end

  assign tok_out     = tok;
  assign srch_out    = srch & ~claim;
  assign stat.valid  = valid;
  assign stat.expire = expire;
  assign stat.claim  = claim;
  assign stat.mode   = mode;

  // Token and search flag move one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok  <= 1'b0;
      srch <= 1'b0;
    end else begin
      tok  <= tok_in;
      srch <= srch_in;
    end
  end

  // Valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (claim) begin
      valid <= 1'b1;
    end else if (clr_hit) begin
      valid <= 1'b0;
    end
  end

  // Slot payload: written on claim, counted down on tick, reloaded on expiry
  always_ff @(posedge clk) begin
    if (claim) begin
      reload <= bus.reload;
      count  <= bus.count;
      mode   <= bus.mode;
    end else if (expire) begin
      count <= reload;
    end else if (act_tick) begin
      count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/ptt_ctrl.sv =====
// Sequencer: accepts commands, runs the dividers, launches the token
// and turns the row status into result transactions.
module ptt_ctrl #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  parameter int STEP_MS   = ptt_pkg::STEP_MS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ptt_pkg::CMD_W-1:0]  cmd,
  input  logic [ptt_pkg::DATA_W-1:0] period_ms,
  input  logic [ptt_pkg::DATA_W-1:0] elapsed_ms,
  input  logic [ptt_pkg::MODE_W-1:0] dispatch_mode,
  input  logic [ptt_pkg::SLOT_W-1:0] slot_id,
  input  logic [NUM_SLOTS-1:0]       valid_vec,
  input  ptt_pkg::scan_stat_t        scan,
  output logic                       busy,
  output logic                       launch,
  output logic                       launch_srch,
  output ptt_pkg::cell_bus_t         bus,
  output logic                       result_strobe,
  output logic                       kind,
  output logic [ptt_pkg::STAT_W-1:0] status,
  output logic [ptt_pkg::SLOT_W-1:0] slot,
  output logic [ptt_pkg::MODE_W-1:0] mode_out,
  output logic                       last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [ptt_pkg::DATA_W-1:0] STEP_C = ptt_pkg::DATA_W'(STEP_MS);
  localparam logic [ptt_pkg::SLOT_W:0]   NSLOT_C = (ptt_pkg::SLOT_W + 1)'(NUM_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  typedef struct packed {
    logic                       kind;
    logic [ptt_pkg::STAT_W-1:0] status;
    logic [ptt_pkg::SLOT_W-1:0] slot;
    logic [ptt_pkg::MODE_W-1:0] mode;
    logic                       last;
  } res_t;

  function automatic res_t mk_res(input logic k, input logic [ptt_pkg::STAT_W-1:0] st,
                                  input logic [ptt_pkg::SLOT_W-1:0] sl,
                                  input logic [ptt_pkg::MODE_W-1:0] md, input logic lt);
    res_t r;
    r.kind   = k;
    r.status = st;
    r.slot   = sl;
    r.mode   = md;
    r.last   = lt;
    return r;
  endfunction

  state_t                     state;
  logic                       op_tick;
  logic                       op_reg;
  logic [IDX_W-1:0]           pos;
  logic                       pend_v;
  logic [IDX_W-1:0]           pend_slot;
  logic [ptt_pkg::MODE_W-1:0] pend_mode;
  logic [ptt_pkg::MODE_W-1:0] mode_q;
  res_t                       res;
  logic                       accept;
  logic                       sid_ok;
  logic                       unreg_hit;
  logic                       div_start;
  logic [ptt_pkg::DATA_W-1:0] first_ms;
  logic                       run_a;
  logic                       run_b;
  logic [ptt_pkg::DATA_W-1:0] q_reload;
  logic [ptt_pkg::DATA_W-1:0] q_count;

  // Command decode
  always_comb begin
    busy      = (state != S_IDLE);
    accept    = start & ~busy;
    sid_ok    = ({1'b0, slot_id} < NSLOT_C);
    unreg_hit = sid_ok & valid_vec[slot_id[IDX_W-1:0]];
    div_start = accept & (cmd == ptt_pkg::CMD_REG) & (period_ms >= STEP_C);
    first_ms  = (elapsed_ms >= period_ms) ? '0 : period_ms - elapsed_ms;
  end

  // Token launch into the first cell
  always_comb begin
    launch_srch = (state == S_DIV) & ~run_a;
    launch      = launch_srch | (accept & (cmd == ptt_pkg::CMD_TICK));
  end

  // Broadcast to the cells
  always_comb begin
    bus.op_tick = op_tick;
    bus.op_reg  = op_reg;
    bus.clr_en  = accept & (cmd == ptt_pkg::CMD_UNREG) & unreg_hit;
    bus.clr_idx = slot_id;
    bus.reload  = q_reload;
    bus.count   = q_count;
    bus.mode    = mode_q;
  end

  ptt_div #(.STEP_MS(STEP_MS)) u_div_reload (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (period_ms),
    .run      (run_a),
    .quotient (q_reload)
  );

  ptt_div #(.STEP_MS(STEP_MS)) u_div_count (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (first_ms),
    .run      (run_b),
    .quotient (q_count)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op_tick       <= 1'b0;
      op_reg        <= 1'b0;
      pend_v        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (cmd)
              ptt_pkg::CMD_TICK: begin
                op_tick <= 1'b1;
                pos     <= '0;
                pend_v  <= 1'b0;
                state   <= S_SCAN;
              end
              ptt_pkg::CMD_REG: begin
                if (period_ms < STEP_C) begin
                  result_strobe <= 1'b1;
                  res <= mk_res(ptt_pkg::KIND_REPLY, ptt_pkg::ST_PERIOD, '0, '0, 1'b1);
                end else begin
                  mode_q <= dispatch_mode;
                  state  <= S_DIV;
                end
              end
              ptt_pkg::CMD_UNREG: begin
                result_strobe <= 1'b1;
                res <= mk_res(ptt_pkg::KIND_REPLY,
                              unreg_hit ? ptt_pkg::ST_OK : ptt_pkg::ST_NOTFOUND,
                              slot_id, '0, 1'b1);
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (!run_a) begin
            op_reg <= 1'b1;
            pos    <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          pos <= pos + 1'b1;
          if (op_tick) begin
            // hold each expiry one hit back so the final one can carry last
            if (scan.hit) begin
              if (pend_v) begin
                result_strobe <= 1'b1;
                res <= mk_res(ptt_pkg::KIND_EXPIRY, ptt_pkg::ST_OK,
                              ptt_pkg::SLOT_W'(pend_slot), pend_mode, 1'b0);
              end
              pend_slot <= pos;
              pend_mode <= scan.mode;
              pend_v    <= 1'b1;
            end
            if (pos == LAST_IDX) begin
              state <= S_FLUSH;
            end
          end else begin
            if (scan.claim) begin
              result_strobe <= 1'b1;
              res <= mk_res(ptt_pkg::KIND_REPLY, ptt_pkg::ST_OK,
                            ptt_pkg::SLOT_W'(pos), '0, 1'b1);
            end else if ((pos == LAST_IDX) && scan.srch_end) begin
              result_strobe <= 1'b1;
              res <= mk_res(ptt_pkg::KIND_REPLY, ptt_pkg::ST_FULL, '0, '0, 1'b1);
            end
            if (pos == LAST_IDX) begin
              op_reg <= 1'b0;
              state  <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (pend_v) begin
            result_strobe <= 1'b1;
            res <= mk_res(ptt_pkg::KIND_EXPIRY, ptt_pkg::ST_OK,
                          ptt_pkg::SLOT_W'(pend_slot), pend_mode, 1'b1);
          end
          pend_v  <= 1'b0;
          op_tick <= 1'b0;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign kind     = res.kind;
  assign status   = res.status;
  assign slot     = res.slot;
  assign mode_out = res.mode;
  assign last     = res.last;

  // Both dividers run in lockstep
  logic div_skew;
  assign div_skew = run_a ^ run_b;

  always_ff @(posedge clk) begin
    if (!rst && div_skew) begin
      $error("ptt_ctrl: dividers out of step");
    end
  end

endmodule

// ===== rtl/periodic_task_timer_table_core.sv =====
// Channel  | Signals                                            | Handshake
// ---------+----------------------------------------------------+-------------------------
// command  | cmd, period_ms, elapsed_ms, dispatch_mode, slot_id | taken when start & !busy
// result   | kind, status, slot, mode_out, last                 | one cycle on result_strobe
//
// Unregister and a rejected period reply in the cycle after the command; busy stays low.
// Tick: busy while the token walks the slot row one cell per cycle, then a flush
// step; expiries come out in slot order, the final one as busy drops.
// Register: busy through a reciprocal-multiply divide by STEP_MS, with the dividend
// and then the product registered, then the walk that claims the lowest free slot.
// Synchronous reset clears all valid marks; the result side cannot stall.
module periodic_task_timer_table_core #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  parameter int STEP_MS   = ptt_pkg::STEP_MS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [ptt_pkg::CMD_W-1:0]  cmd,
  input  logic [ptt_pkg::DATA_W-1:0] period_ms,
  input  logic [ptt_pkg::DATA_W-1:0] elapsed_ms,
  input  logic [ptt_pkg::MODE_W-1:0] dispatch_mode,
  input  logic [ptt_pkg::SLOT_W-1:0] slot_id,
  output logic                       result_strobe,
  output logic                       kind,
  output logic [ptt_pkg::STAT_W-1:0] status,
  output logic [ptt_pkg::SLOT_W-1:0] slot,
  output logic [ptt_pkg::MODE_W-1:0] mode_out,
  output logic                       last
);

  ptt_pkg::cell_bus_t  bus;
  ptt_pkg::cell_stat_t cstat [NUM_SLOTS];
  ptt_pkg::scan_stat_t scan;
  logic                launch;
  logic                launch_srch;
  logic [NUM_SLOTS:0]  tok_link;
  logic [NUM_SLOTS:0]  srch_link;
  logic [NUM_SLOTS-1:0] valid_vec;
  logic [NUM_SLOTS-1:0] tok_vec;

  assign tok_link[0]  = launch;
  assign srch_link[0] = launch_srch;

  // Row of slot cells
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ptt_cell #(.CELL_ID(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .bus      (bus),
      .tok_in   (tok_link[i]),
      .srch_in  (srch_link[i]),
      .tok_out  (tok_link[i+1]),
      .srch_out (srch_link[i+1]),
      .stat     (cstat[i])
    );
    assign valid_vec[i] = cstat[i].valid;
    assign tok_vec[i]   = tok_link[i+1];
  end

  // Merge the status of the token holder
  always_comb begin
    scan.hit      = 1'b0;
    scan.claim    = 1'b0;
    scan.mode     = '0;
    scan.srch_end = srch_link[NUM_SLOTS];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      scan.hit   = scan.hit | cstat[i].expire;
      scan.claim = scan.claim | cstat[i].claim;
      scan.mode  = scan.mode | (cstat[i].expire ? cstat[i].mode : '0);
    end
  end

  ptt_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .STEP_MS   (STEP_MS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .period_ms     (period_ms),
    .elapsed_ms    (elapsed_ms),
    .dispatch_mode (dispatch_mode),
    .slot_id       (slot_id),
    .valid_vec     (valid_vec),
    .scan          (scan),
    .busy          (busy),
    .launch        (launch),
    .launch_srch   (launch_srch),
    .bus           (bus),
    .result_strobe (result_strobe),
    .kind          (kind),
    .status        (status),
    .slot          (slot),
    .mode_out      (mode_out),
    .last          (last)
  );

  // At most one cell holds the token
  a_tok_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vec))
    else $error("token held by more than one cell");

  // No token in the row while idle
  a_tok_idle: assert property (@(posedge clk) disable iff (rst) !busy |-> (tok_vec == '0))
    else $error("token in flight while idle");

  // A register claims at most one slot per transaction
  a_claim_once: assert property (@(posedge clk) disable iff (rst)
    scan.claim |=> !scan.claim)
    else $error("two slots claimed");

  // Command replies are always single and final
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (kind == ptt_pkg::KIND_REPLY)) |-> last)
    else $error("reply without last");

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = ptt_pkg::DATA_W;
  localparam int SLOT_W = ptt_pkg::SLOT_W;
  localparam int CMD_W  = ptt_pkg::CMD_W;
  localparam int MODE_W = ptt_pkg::MODE_W;
  localparam int STAT_W = ptt_pkg::STAT_W;

  localparam int NSLOT = ptt_pkg::NUM_SLOTS_DEF;
  localparam int STEP = ptt_pkg::STEP_MS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_DATA = 24'hFFFFFF;
  localparam int RANDOM_ITEMS = 195;
  // register is the slowest transaction: divide plus slot walk, plus sender gap
  localparam int WATCHDOG_LIMIT = 40 * (2 + NSLOT + 20);
  localparam int DRAIN_CYCLES = 2 * (2 + NSLOT) + 20;

  typedef struct packed {
    logic              kind;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [MODE_W-1:0] mode;
    logic              last;
  } timer_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] period_ms;
  logic [DATA_W-1:0] elapsed_ms;
  logic [MODE_W-1:0] dispatch_mode;
  logic [SLOT_W-1:0] slot_id;
  logic              result_strobe;
  logic              kind;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot;
  logic [MODE_W-1:0] mode_out;
  logic              last;

  periodic_task_timer_table_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .period_ms    (period_ms),
    .elapsed_ms   (elapsed_ms),
    .dispatch_mode(dispatch_mode),
    .slot_id      (slot_id),
    .result_strobe(result_strobe),
    .kind         (kind),
    .status       (status),
    .slot         (slot),
    .mode_out     (mode_out),
    .last         (last)
  );

  // Shadow copy of the slot table
  logic              tbl_valid [NSLOT];
  logic [DATA_W-1:0] tbl_reload[NSLOT];
  logic [DATA_W-1:0] tbl_count [NSLOT];
  logic [MODE_W-1:0] tbl_mode  [NSLOT];
  int                tbl_used;

  timer_result_t pending_results[$];
  int            errors;
  int            quiet_cycles;
  bit            idle_on;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Work out the results of one accepted transaction and update the shadow table
  task automatic predict_timer_results(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] p,
                                       input logic [DATA_W-1:0] e, input logic [MODE_W-1:0] m,
                                       input logic [SLOT_W-1:0] s);
    int            fired[$];
    int            free_idx;
    timer_result_t r;
    r = '0;
    free_idx = -1;
    case (c)
      ptt_pkg::CMD_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_count[i] > 1) tbl_count[i] = tbl_count[i] - 1'b1;
            else begin
              tbl_count[i] = tbl_reload[i];
              fired.push_back(i);
            end
          end
        end
        foreach (fired[k]) begin
          r.kind   = ptt_pkg::KIND_EXPIRY;
          r.status = ptt_pkg::ST_OK;
          r.slot   = SLOT_W'(fired[k]);
          r.mode   = tbl_mode[fired[k]];
          r.last   = (k == fired.size() - 1);
          pending_results.push_back(r);
        end
      end
      ptt_pkg::CMD_REG: begin
        r.kind = ptt_pkg::KIND_REPLY;
        r.last = 1'b1;
        if (p < STEP) r.status = ptt_pkg::ST_PERIOD;
        else begin
          if (tbl_used < NSLOT) begin
            for (int i = NSLOT - 1; i >= 0; i--)
              if (!tbl_valid[i]) free_idx = i;
          end
          if (free_idx < 0) r.status = ptt_pkg::ST_FULL;
          else begin
            tbl_valid[free_idx]  = 1'b1;
            tbl_reload[free_idx] = DATA_W'(p / STEP);
            tbl_count[free_idx]  = (e >= p) ? '0 : DATA_W'((p - e) / STEP);
            tbl_mode[free_idx]   = m;
            tbl_used++;
            r.status = ptt_pkg::ST_OK;
            r.slot   = SLOT_W'(free_idx);
          end
        end
        pending_results.push_back(r);
      end
      ptt_pkg::CMD_UNREG: begin
        r.kind = ptt_pkg::KIND_REPLY;
        r.last = 1'b1;
        r.slot = s;
        if (s < NSLOT && tbl_valid[s]) begin
          tbl_valid[s] = 1'b0;
          if (tbl_used > 0) tbl_used--;
          r.status = ptt_pkg::ST_OK;
        end else begin
          r.status = ptt_pkg::ST_NOTFOUND;
        end
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Drive one transaction, wait for the handshake, then predict
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] p,
                           input logic [DATA_W-1:0] e, input logic [MODE_W-1:0] m,
                           input logic [SLOT_W-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    cmd           <= c;
    period_ms     <= p;
    elapsed_ms    <= e;
    dispatch_mode <= m;
    slot_id       <= s;
    do @(posedge clk); while (busy);
    predict_timer_results(c, p, e, m, s);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker: the receiver takes every strobe
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %s",
                 $time, $sformatf("kind=%0d status=%0d slot=%0d mode=%0d last=%0d",
                                  kind, status, slot, mode_out, last));
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, kind);
        check_field("status", want.status, status);
        check_field("slot", want.slot, slot);
        check_field("mode_out", want.mode, mode_out);
        check_field("last", want.last, last);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Commands on an empty table
  task automatic test_empty_table();
    send_item(ptt_pkg::CMD_TICK, DATA_W'(MAX_DATA), DATA_W'(MAX_DATA), 2'd3, 6'd63);
    send_item(CMD_UNUSED, 24'd50, 24'd0, 2'd1, 6'd0);
    send_item(ptt_pkg::CMD_UNREG, 24'd0, 24'd0, 2'd0, 6'd0);
    send_item(ptt_pkg::CMD_UNREG, 24'd0, 24'd0, 2'd0, 6'd63);
  endtask

  // Period check, elapsed at or past the period, field extremes
  task automatic test_register_checks();
    send_item(ptt_pkg::CMD_REG, 24'd0, 24'd0, 2'd0, 6'd0);
    send_item(ptt_pkg::CMD_REG, DATA_W'(STEP - 1), 24'd0, 2'd3, 6'd0);
    send_item(ptt_pkg::CMD_REG, DATA_W'(STEP), 24'd0, 2'd1, 6'd63);
    send_item(ptt_pkg::CMD_REG, DATA_W'(MAX_DATA), DATA_W'(MAX_DATA), 2'd3, 6'd0);
    send_item(ptt_pkg::CMD_REG, 24'd25, 24'd30, 2'd2, 6'd0);
    send_item(ptt_pkg::CMD_REG, 24'd100, 24'd15, 2'd0, 6'd0);
    send_item(ptt_pkg::CMD_TICK, 24'd0, 24'd0, 2'd0, 6'd0);
    send_item(ptt_pkg::CMD_TICK, 24'd0, 24'd0, 2'd0, 6'd0);
  endtask

  // Fill the table, then full and period-below-step while full, then reuse a slot
  task automatic test_table_full();
    for (int i = 0; i < NSLOT - 4; i++)
      send_item(ptt_pkg::CMD_REG, DATA_W'((i + 1) * STEP + i), DATA_W'(i * 3),
                MODE_W'(i), 6'd0);
    send_item(ptt_pkg::CMD_REG, 24'd40, 24'd0, 2'd1, 6'd0);
    send_item(ptt_pkg::CMD_REG, 24'd5, 24'd0, 2'd1, 6'd0);
    send_item(ptt_pkg::CMD_UNREG, 24'd0, 24'd0, 2'd0, 6'd7);
    send_item(ptt_pkg::CMD_REG, 24'd20, 24'd20, 2'd2, 6'd0);
    send_item(ptt_pkg::CMD_TICK, 24'd0, 24'd0, 2'd0, 6'd0);
  endtask

  // Random mix, biased toward short periods so slots keep expiring
  task automatic test_random();
    logic [CMD_W-1:0]  c;
    logic [MODE_W-1:0] m;
    logic [SLOT_W-1:0] s;
    int p;
    int e;
    int pick;
    int base;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      p = $urandom_range(0, MAX_DATA);
      e = $urandom_range(0, MAX_DATA);
      m = MODE_W'($urandom_range(0, 3));
      s = SLOT_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 5) c = CMD_UNUSED;
      else if (pick < 50) c = ptt_pkg::CMD_TICK;
      else if (pick < ((tbl_used >= 12) ? 62 : 80)) c = ptt_pkg::CMD_REG;
      else c = ptt_pkg::CMD_UNREG;

      if (c == ptt_pkg::CMD_REG) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) p = $urandom_range(0, STEP - 1);
        else if (pick < 70) p = $urandom_range(STEP, 6 * STEP);
        else if (pick < 85) p = $urandom_range(STEP, 30 * STEP);
        pick = $urandom_range(0, 99);
        if (pick < 50) e = $urandom_range(0, p);
        else if (pick < 75) e = (p + 40 > MAX_DATA) ? MAX_DATA : p + $urandom_range(0, 40);
      end else if (c == ptt_pkg::CMD_UNREG && tbl_used > 0 && $urandom_range(0, 9) < 7) begin
        // aim at a live slot most of the time
        base = $urandom_range(0, NSLOT - 1);
        for (int k = NSLOT - 1; k >= 0; k--)
          if (tbl_valid[(base + k) % NSLOT]) s = SLOT_W'((base + k) % NSLOT);
      end
      send_item(c, DATA_W'(p), DATA_W'(e), m, s);
    end
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = ptt_pkg::CMD_TICK;
    period_ms     = '0;
    elapsed_ms    = '0;
    dispatch_mode = '0;
    slot_id       = '0;
    errors        = 0;
    quiet_cycles  = 0;
    idle_on       = 1'b1;
    tbl_used      = 0;
    foreach (tbl_valid[i]) begin
      tbl_valid[i]  = 1'b0;
      tbl_reload[i] = '0;
      tbl_count[i]  = '0;
      tbl_mode[i]   = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_register_checks();
    test_table_full();
    test_random();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ptt_pkg.sv
rtl/ptt_div.sv
rtl/ptt_cell.sv
rtl/ptt_ctrl.sv
rtl/periodic_task_timer_table_core.sv
dv/tb.sv
